/* sv/fab_pkg.sv */
// ---------------------------------------------------------------------------
// fab_pkg: shared types and constants of the first-fit block allocator
// Status and function codes, register map, fixed field widths, control states.
// ---------------------------------------------------------------------------
package fab_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned REQ_W    = 24;
  localparam int unsigned BLK_W    = 25;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Stream payload widths (packed, rounded up to whole bytes)
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 72;

  // Block layout
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ALIGN_BYTES  = 4;
  localparam int unsigned SIZE_PAD     = 4;

  // Register map, selected by paddr[2]
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_SPACE     = 2'd1,
    STAT_TABLE_FULL   = 2'd2,
    STAT_FREE_IGNORED = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

endpackage

/* sv/first_fit_block_allocator.sv */
// ---------------------------------------------------------------------------
// first_fit_block_allocator: alloc/free of heap blocks from a block table
// Reuses the most recently freed block that fits, else carves at a bump
// pointer. The table sits in a one-read, one-write memory that is scanned
// entry by entry by a small sequencer.
// ---------------------------------------------------------------------------
// Flow: a request that reuses or frees a block makes a scan pass and an update
//   pass over the table memory; a carve or a failed request makes the scan pass
//   only; a free of address zero goes straight to the result. A held result
//   stalls the block until taken.
// Requests: one at a time; the next is taken after the result is loaded into the output register.
// Reset: the table is empty, heap_base 0, heap_limit all ones, bytes used 0.
// The table memory needs no clearing pass: only carved entries are read.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request: [23:0] request_size, [55:24] user_address
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fab_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // request: [0] func
  input  logic                          s_axis_tuser,
  // result: [31:0] result_address, [33:32] status, [65:34] bytes_used, rest 0
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fab_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fab_pkg::PADDR_W-1:0]   paddr,
  input  logic [fab_pkg::PDATA_W-1:0]   pwdata,
  output logic [fab_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import fab_pkg::*;

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned RW = AW;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [BLK_W-1:0]  bytes;
    logic              is_free;
    logic [RW-1:0]     rec;
  } entry_t;

  // Control state
  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_q, found_d;
  logic [CW-1:0]     carved_q, carved_d;
  logic [ADDR_W-1:0] bump_q, bump_d;
  logic [ADDR_W-1:0] used_q, used_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] limit_q, limit_d;
  logic              m_valid_q, m_valid_d;

  // Payload state
  func_e             func_q, func_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [ADDR_W-1:0] uaddr_q, uaddr_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [RW-1:0]     best_q, best_d;
  logic [AW-1:0]     tgt_idx_q, tgt_idx_d;
  logic [ADDR_W-1:0] tgt_start_q, tgt_start_d;
  logic [BLK_W-1:0]  tgt_bytes_q, tgt_bytes_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_used_q;

  // Table memory
  entry_t            blk_mem_q [MAX_BLOCKS];
  entry_t            rd_entry_q;
  logic              rd_en;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;

  logic              in_xfer;
  logic              out_load;
  logic              cfg_we;
  logic              issue;
  logic [BLK_W-1:0]  raw_size;
  logic [ADDR_W:0]   carve_end;
  entry_t            upd_entry;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite && pready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - 2*ADDR_W - STATUS_W){1'b0}},
                          out_used_q, out_status_q, out_addr_q};

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_HEAP_BASE:  prdata = base_q;
      REG_HEAP_LIMIT: prdata = limit_q;
      default:        prdata = base_q;
    endcase
  end

  // Size of the block for an allocate: request plus header and pad, aligned down
  assign raw_size = BLK_W'(s_axis_tdata[REQ_W-1:0]) + BLK_W'(HEADER_BYTES + SIZE_PAD);

  // One table entry a cycle while the index runs below the carved count
  assign issue     = (idx_q < carved_q);
  assign carve_end = {1'b0, bump_q} + (ADDR_W+1)'(blk_q);

  // Entry rewritten during the update pass
  always_comb begin
    upd_entry = rd_entry_q;
    if (func_q == FUNC_ALLOC) begin
      if (rd_idx_q == tgt_idx_q) begin
        upd_entry.is_free = 1'b0;
        upd_entry.rec     = '0;
      end else if (rd_entry_q.is_free && (rd_entry_q.rec > best_q)) begin
        upd_entry.rec = rd_entry_q.rec - RW'(1);
      end
    end else begin
      if (rd_idx_q == tgt_idx_q) begin
        upd_entry.is_free = 1'b1;
        upd_entry.rec     = '0;
      end else if (rd_entry_q.is_free) begin
        upd_entry.rec = rd_entry_q.rec + RW'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    rd_vld_d     = 1'b0;
    found_d      = found_q;
    carved_d     = carved_q;
    bump_d       = bump_q;
    used_d       = used_q;
    base_d       = base_q;
    limit_d      = limit_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    func_d       = func_q;
    blk_d        = blk_q;
    uaddr_d      = uaddr_q;
    rd_idx_d     = idx_q[AW-1:0];
    best_d       = best_q;
    tgt_idx_d    = tgt_idx_q;
    tgt_start_d  = tgt_start_q;
    tgt_bytes_d  = tgt_bytes_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = upd_entry;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          func_d   = func_e'(s_axis_tuser);
          blk_d    = raw_size - (raw_size % BLK_W'(ALIGN_BYTES));
          uaddr_d  = s_axis_tdata[REQ_W +: ADDR_W];
          idx_d    = '0;
          found_d  = 1'b0;
          if ((func_e'(s_axis_tuser) == FUNC_FREE) &&
              (s_axis_tdata[REQ_W +: ADDR_W] == '0)) begin
            res_addr_d   = '0;
            res_status_d = STAT_OK;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rd_en    = issue;
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        // Track the most recently freed block that fits, or the first allocated block at the address
        if (rd_vld_q) begin
          if (func_q == FUNC_ALLOC) begin
            if (rd_entry_q.is_free && (rd_entry_q.bytes >= blk_q) &&
                (!found_q || (rd_entry_q.rec < best_q))) begin
              found_d     = 1'b1;
              best_d      = rd_entry_q.rec;
              tgt_idx_d   = rd_idx_q;
              tgt_start_d = rd_entry_q.start;
              tgt_bytes_d = rd_entry_q.bytes;
            end
          end else begin
            if (!found_q && !rd_entry_q.is_free &&
                ((rd_entry_q.start + ADDR_W'(HEADER_BYTES)) == uaddr_q)) begin
              found_d     = 1'b1;
              tgt_idx_d   = rd_idx_q;
              tgt_start_d = rd_entry_q.start;
              tgt_bytes_d = rd_entry_q.bytes;
            end
          end
        end
        if (!issue && !rd_vld_q) begin
          idx_d   = '0;
          state_d = found_q ? ST_UPDATE : ST_DECIDE;
        end
      end

      ST_UPDATE: begin
        rd_en    = issue;
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        // Rewrite each entry in the cycle after its read
        mem_we = rd_vld_q;
        if (!issue && !rd_vld_q) begin
          res_status_d = STAT_OK;
          if (func_q == FUNC_ALLOC) begin
            used_d     = used_q + ADDR_W'(tgt_bytes_q);
            res_addr_d = tgt_start_q + ADDR_W'(HEADER_BYTES);
          end else begin
            used_d     = used_q - ADDR_W'(tgt_bytes_q);
            res_addr_d = '0;
          end
          state_d = ST_RESP;
        end
      end

      ST_DECIDE: begin
        res_addr_d = '0;
        if (func_q == FUNC_FREE) begin
          res_status_d = STAT_FREE_IGNORED;
        end else if (carved_q == CW'(MAX_BLOCKS)) begin
          res_status_d = STAT_TABLE_FULL;
        end else if (carve_end > {1'b0, limit_q}) begin
          res_status_d = STAT_NO_SPACE;
        end else begin
          // Carve a new block at the bump pointer
          mem_we            = 1'b1;
          mem_waddr         = carved_q[AW-1:0];
          mem_wdata.start   = bump_q;
          mem_wdata.bytes   = blk_q;
          mem_wdata.is_free = 1'b0;
          mem_wdata.rec     = '0;
          carved_d          = carved_q + CW'(1);
          bump_d            = carve_end[ADDR_W-1:0];
          used_d            = used_q + ADDR_W'(blk_q);
          res_addr_d        = bump_q + ADDR_W'(HEADER_BYTES);
          res_status_d      = STAT_OK;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration writes; heap_base also reloads the bump pointer
    if (cfg_we) begin
      if (paddr[2] == REG_HEAP_BASE) begin
        base_d = pwdata;
        bump_d = pwdata;
      end else begin
        limit_d = pwdata;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      carved_q  <= '0;
      bump_q    <= '0;
      used_q    <= '0;
      base_q    <= '0;
      limit_q   <= '1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      carved_q  <= carved_d;
      bump_q    <= bump_d;
      used_q    <= used_d;
      base_q    <= base_d;
      limit_q   <= limit_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    blk_q        <= blk_d;
    uaddr_q      <= uaddr_d;
    rd_idx_q     <= rd_idx_d;
    best_q       <= best_d;
    tgt_idx_q    <= tgt_idx_d;
    tgt_start_q  <= tgt_start_d;
    tgt_bytes_q  <= tgt_bytes_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_used_q   <= used_q;
    end
  end

  // Block table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_entry_q <= blk_mem_q[idx_q[AW-1:0]];
    end
  end

endmodule

/* tb/fab_checker.sv */
// ---------------------------------------------------------------------------
// fab_checker: result predictor and comparator for the block allocator
// Watches the request, result and configuration channels, keeps its own copy
// of the block table, and checks every result transfer against the oldest
// predicted reply.
// ---------------------------------------------------------------------------
module fab_checker #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request: [23:0] request_size, [55:24] user_address
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [fab_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // request: [0] func
  input  logic                          s_axis_tuser,
  // result: [31:0] result_address, [33:32] status, [65:34] bytes_used
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [fab_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fab_pkg::PADDR_W-1:0]   paddr,
  input  logic [fab_pkg::PDATA_W-1:0]   pwdata,
  input  logic                          pready,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fab_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
    logic [ADDR_W-1:0] used;
  } reply_t;

  // Allocator state as predicted
  logic [ADDR_W-1:0] heap_base_q;
  logic [ADDR_W-1:0] heap_limit_q;
  logic [ADDR_W-1:0] bump_q;
  logic [ADDR_W-1:0] used_q;
  int                carved_q;
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [BLK_W-1:0]  blk_len   [MAX_BLOCKS];
  bit                blk_taken [MAX_BLOCKS];
  bit                blk_free  [MAX_BLOCKS];
  int unsigned       blk_rank  [MAX_BLOCKS];

  reply_t      reply_q [$];
  int unsigned mismatches;

  // Reuse the most recently freed block that fits, else carve at the bump pointer
  task automatic serve_alloc(input logic [REQ_W-1:0] req, output reply_t r);
    logic [ADDR_W-1:0] need;
    int                pick;
    int unsigned       best;
    need = ADDR_W'(req) + HEADER_BYTES + SIZE_PAD;
    need = need - need % ALIGN_BYTES;
    pick = -1;
    best = 32'hFFFF_FFFF;
    for (int i = 0; i < carved_q; i++) begin
      if (blk_taken[i] && blk_free[i] && ADDR_W'(blk_len[i]) >= need &&
          blk_rank[i] < best) begin
        best = blk_rank[i];
        pick = i;
      end
    end
    if (pick >= 0) begin
      // close the gap left in the free ranks
      for (int i = 0; i < carved_q; i++) begin
        if (blk_taken[i] && blk_free[i] && blk_rank[i] > best) blk_rank[i]--;
      end
      blk_free[pick] = 1'b0;
      blk_rank[pick] = 0;
      used_q = used_q + ADDR_W'(blk_len[pick]);
      r = '{blk_start[pick] + HEADER_BYTES, STAT_OK, used_q};
    end else if (carved_q >= MAX_BLOCKS) begin
      r = '{'0, STAT_TABLE_FULL, used_q};
    end else if ({1'b0, bump_q} + {1'b0, need} > {1'b0, heap_limit_q}) begin
      r = '{'0, STAT_NO_SPACE, used_q};
    end else begin
      blk_start[carved_q] = bump_q;
      blk_len[carved_q]   = BLK_W'(need);
      blk_taken[carved_q] = 1'b1;
      blk_free[carved_q]  = 1'b0;
      blk_rank[carved_q]  = 0;
      carved_q++;
      bump_q = bump_q + need;
      used_q = used_q + need;
      r = '{bump_q - need + HEADER_BYTES, STAT_OK, used_q};
    end
  endtask

  // Release the lowest-index allocated block at this user address
  task automatic serve_free(input logic [ADDR_W-1:0] addr, output reply_t r);
    logic [ADDR_W-1:0] user;
    int                hit;
    hit = -1;
    if (addr == '0) begin
      r = '{'0, STAT_OK, used_q};
      return;
    end
    for (int i = 0; i < carved_q; i++) begin
      user = blk_start[i] + HEADER_BYTES;
      if (hit < 0 && blk_taken[i] && !blk_free[i] && user == addr) hit = i;
    end
    if (hit < 0) begin
      r = '{'0, STAT_FREE_IGNORED, used_q};
      return;
    end
    for (int i = 0; i < carved_q; i++) begin
      if (blk_taken[i] && blk_free[i]) blk_rank[i]++;
    end
    blk_free[hit] = 1'b1;
    blk_rank[hit] = 0;
    used_q = used_q - ADDR_W'(blk_len[hit]);
    r = '{'0, STAT_OK, used_q};
  endtask

  task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%m: %s at %0t: expected addr %h status %s used %h, got addr %h status %s used %h",
               what, $realtime, want.addr, want.status.name(), want.used,
               got.addr, got.status.name(), got.used);
    end
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      heap_base_q  = '0;
      heap_limit_q = '1;
      bump_q       = '0;
      used_q       = '0;
      carved_q     = 0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        blk_start[i] = '0;
        blk_len[i]   = '0;
        blk_taken[i] = 1'b0;
        blk_free[i]  = 1'b0;
        blk_rank[i]  = 0;
      end
      reply_q.delete();
      mismatches = 0;
    end else begin
      // Compare the result transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], status_e'(m_axis_tdata[33:32]), m_axis_tdata[65:34]};
        if (reply_q.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = reply_q.pop_front();
          if (got.addr !== want.addr || got.status !== want.status ||
              got.used !== want.used) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      // Track register writes; the base also reloads the bump pointer
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEAP_BASE) begin
          heap_base_q = pwdata;
          bump_q      = pwdata;
        end else begin
          heap_limit_q = pwdata;
        end
      end
      // Predict the reply to each accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        if (func_e'(s_axis_tuser) == FUNC_ALLOC) begin
          serve_alloc(s_axis_tdata[23:0], want);
        end else begin
          serve_free(s_axis_tdata[55:24], want);
        end
        reply_q.push_back(want);
      end
    end
    pending_o    = reply_q.size();
    fail_count_o = mismatches;
  end

endmodule

/* tb/tb_first_fit_block_allocator.sv */
// ---------------------------------------------------------------------------
// tb_first_fit_block_allocator: stimulus and verdict for the block allocator
// Resets once, runs a directed sequence over the corner cases of alloc and
// free, then several randomized phases under different heap windows with
// random valid and ready gaps outside one calm phase. The checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fab_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned CLK_HALF     = 5;
  // longest request is a scan and an update pass over a full table
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_BLOCKS + 16;
  localparam int unsigned STALL_LIMIT  = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // request: [23:0] request_size, [55:24] user_address
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  // request: [0] func
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // result: [31:0] result_address, [33:32] status, [65:34] bytes_used, rest 0
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;

  // Addresses handed out, and a short history of released ones
  logic [ADDR_W-1:0] live_q  [$];
  logic [ADDR_W-1:0] freed_q [$];

  always #(CLK_HALF) clk_i = ~clk_i;

  first_fit_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fab_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result side now and then, except in calm stretches
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 6);
  end

  // Collect granted addresses so that frees can target live blocks
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready && m_axis_tdata[31:0] != '0) begin
      live_q.push_back(m_axis_tdata[31:0]);
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_first_fit_block_allocator: done, errors");
      $finish;
    end
  end

  // Present one request and hold it until the transfer; valid stays high
  task automatic put_req(input func_e f, input logic [REQ_W-1:0] size,
                         input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {addr, size};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic alloc_req(input logic [REQ_W-1:0] size);
    put_req(FUNC_ALLOC, size, $urandom());
  endtask

  task automatic free_req(input logic [ADDR_W-1:0] addr);
    put_req(FUNC_FREE, REQ_W'($urandom()), addr);
  endtask

  // Drop valid, wait for every reply, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic sel, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small allocs and frees of live blocks; some double frees and noise
  task automatic random_item();
    int unsigned       roll;
    int unsigned       k;
    int unsigned       idx;
    logic [REQ_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(99);
    k    = $urandom_range(99);
    if (roll < 55) begin
      if (k < 80) size = REQ_W'($urandom_range(63));
      else if (k < 95) size = REQ_W'($urandom_range(4095, 64));
      else size = REQ_W'($urandom());
      alloc_req(size);
    end else begin
      if (k < 75 && live_q.size() > 0) begin
        idx  = $urandom_range(live_q.size() - 1);
        addr = live_q[idx];
        live_q.delete(idx);
        freed_q.push_back(addr);
        if (freed_q.size() > 16) void'(freed_q.pop_front());
      end else if (k < 85 && freed_q.size() > 0) begin
        addr = freed_q[$urandom_range(freed_q.size() - 1)];
      end else if (k < 90) begin
        addr = '0;
      end else begin
        addr = $urandom();
      end
      free_req(addr);
    end
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit,
                           input int unsigned count, input bit quiet);
    cfg_write(REG_HEAP_BASE, base);
    cfg_write(REG_HEAP_LIMIT, limit);
    calm <= quiet;
    repeat (count) random_item();
    settle();
    calm <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] c_addr;
    logic [ADDR_W-1:0] d_addr;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_ALLOC;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No-op free, unknown free, smallest and largest requests, rounding
    free_req('0);
    free_req('1);
    alloc_req('0);
    alloc_req('1);
    alloc_req(24'd1);
    alloc_req(24'd2);
    alloc_req(24'd5);
    settle();
    a_addr = live_q[0];
    b_addr = live_q[1];
    c_addr = live_q[2];
    d_addr = live_q[3];

    // Double free, then reuse in most-recent-free order, whole-block reuse
    free_req(a_addr);
    free_req(a_addr);
    free_req(c_addr);
    free_req(d_addr);
    alloc_req('0);
    alloc_req('0);
    free_req(b_addr);
    alloc_req(24'd100);
    alloc_req(24'd4);
    alloc_req('0);
    settle();

    // Reload the bump pointer onto used space: two blocks share one address
    cfg_write(REG_HEAP_BASE, '0);
    alloc_req('0);
    free_req(a_addr);
    free_req(a_addr);
    free_req(a_addr);
    settle();

    // Out of heap space at both register extremes
    cfg_write(REG_HEAP_BASE, '1);
    cfg_write(REG_HEAP_LIMIT, '1);
    alloc_req(24'd16);
    settle();
    cfg_write(REG_HEAP_BASE, '0);
    cfg_write(REG_HEAP_LIMIT, '0);
    alloc_req(24'd200);
    settle();

    // Random phases: tight window, high window until the table fills, then reuse
    run_phase(32'h0010_0000, 32'h0010_0800, 150, 1'b0);
    run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 200, 1'b1);
    run_phase(32'h0000_0000, 32'h0000_0000, 200, 1'b0);
    run_phase(32'h7654_3210, 32'hFFFF_FFFF, 200, 1'b0);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_first_fit_block_allocator: done, clean");
    end else begin
      $display("tb_first_fit_block_allocator: done, errors");
    end
    $finish;
  end

endmodule
